>>> design/bba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg: shared types for the buddy block allocator
// Word structs, status codes, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BADSIZE  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [16:0] request_size;
    logic [31:0] free_address;
  } in_word_t;

  typedef struct packed {
    logic [31:0] block_address;
    logic [1:0]  status;
  } out_word_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_LEVEL,
    S_AFIND,
    S_APOP,
    S_ASPLIT,
    S_APUSH,
    S_FSCAN,
    S_FCMP,
    S_FSHIFT_RD,
    S_FSHIFT_WR,
    S_FPUSH,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic init_wr;     // write offset 0 into the top level's first slot
    logic load;        // capture request
    logic set_want;    // wanted level = current level
    logic align;       // align offset down to the current block size
    logic lvl_up;      // level +1
    logic lvl_dn;      // level -1
    logic idx_clr;     // scan index to 0
    logic idx_inc;     // scan index +1
    logic rd_top;      // read newest entry of current level
    logic rd_idx1;     // read entry at index+1 (default read is at index)
    logic pop;         // count -1, capture read data as offset
    logic push_half;   // push offset+size at current level
    logic push_off;    // push offset at current level
    logic wr_idx;      // write read data at index
    logic take_done;   // count -1, merge offset
    logic set_addr;    // result address from offset
    logic [1:0] status;
    logic set_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bad_size;
    logic is_free;
    logic fits;        // current level holds the request size
    logic at_want;     // level == wanted level
    logic at_top;
    logic cnt_zero;
    logic cnt_full;
    logic idx_end;     // index >= count
    logic idx_last;    // index+1 >= count
    logic match;       // read data equals buddy
  } sts_t;

endpackage
`default_nettype wire

>>> design/bba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ctrl: allocator sequencer
// Walks levels, scans lists, steers the datapath one step a cycle; DONE waits.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            start,
  input  wire            out_taken,
  input  bba_pkg::sts_t  sts,
  output bba_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done
);
  import bba_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else        state_r <= state_nxt;
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    busy      = (state_r != S_IDLE);
    done      = (state_r == S_DONE);
    unique case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_LEVEL;
        end
      end
      S_LEVEL: begin
        // level count-up from minimum to fit request size
        if (sts.bad_size) begin
          cmd.status = ST_BADSIZE; cmd.set_status = 1'b1;
          state_nxt = S_DONE;
        end else if (!sts.fits && !sts.at_top) begin
          cmd.lvl_up = 1'b1;
        end else if (sts.is_free) begin
          cmd.set_want = 1'b1;
          cmd.align    = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_nxt    = S_FSCAN;
        end else begin
          cmd.set_want = 1'b1;
          state_nxt    = S_AFIND;
        end
      end
      S_AFIND: begin
        if (!sts.cnt_zero) begin
          cmd.rd_top = 1'b1;
          state_nxt = S_APOP;
        end else if (sts.at_top) begin
          cmd.status = ST_EMPTY; cmd.set_status = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.lvl_up = 1'b1;
        end
      end
      S_APOP: begin
        cmd.pop = 1'b1;
        state_nxt = S_ASPLIT;
      end
      S_ASPLIT: begin
        if (sts.at_want) begin
          cmd.set_addr = 1'b1;
          cmd.status = ST_OK; cmd.set_status = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.lvl_dn = 1'b1;
          state_nxt = S_APUSH;
        end
      end
      S_APUSH: begin
        // upper half goes on the list one level down
        cmd.push_half = 1'b1;
        state_nxt = S_ASPLIT;
      end
      S_FSCAN: begin
        if (sts.at_top || sts.idx_end) begin
          state_nxt = S_FPUSH;
        end else begin
          state_nxt = S_FCMP;
        end
      end
      S_FCMP: begin
        if (sts.match) begin
          state_nxt = S_FSHIFT_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt = S_FSCAN;
        end
      end
      S_FSHIFT_RD: begin
        if (sts.idx_last) begin
          cmd.take_done = 1'b1;
          cmd.lvl_up = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt = S_FSCAN;
        end else begin
          cmd.rd_idx1 = 1'b1;
          state_nxt = S_FSHIFT_WR;
        end
      end
      S_FSHIFT_WR: begin
        cmd.wr_idx = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt = S_FSHIFT_RD;
      end
      S_FPUSH: begin
        cmd.set_status = 1'b1;
        if (sts.cnt_full) begin
          cmd.status = ST_OVERFLOW;
        end else begin
          cmd.status = ST_OK;
          cmd.push_off = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_taken) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> design/bba_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_dp: allocator datapath
// Free-list memory, per-level counts, offset and level registers.
// ----------------------------------------------------------------------------
module bba_dp #(
  parameter int POOL_LOG2      = 16,
  parameter int MIN_BLOCK_LOG2 = 4,
  parameter int LIST_DEPTH     = 64
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  bba_pkg::cmd_t       cmd,
  input  bba_pkg::in_word_t   req,
  input  wire  [31:0]         pool_base,
  output bba_pkg::sts_t       sts,
  output bba_pkg::out_word_t  result
);
  import bba_pkg::*;

  localparam int NUM_LEVELS = POOL_LOG2 - MIN_BLOCK_LOG2 + 1;
  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int OW = POOL_LOG2;
  localparam int MD = NUM_LEVELS * LIST_DEPTH;
  localparam int MW = $clog2(MD);
  localparam int SW = $clog2(POOL_LOG2 + 1);
  localparam logic [LW-1:0] TOP        = LW'(NUM_LEVELS - 1);
  localparam logic [32:0]   POOL_BYTES = 33'd1 << POOL_LOG2;
  localparam logic [CW-1:0] DEPTH_C    = CW'(LIST_DEPTH);
  localparam logic [MW-1:0] TOP_BASE   = MW'((NUM_LEVELS - 1) * LIST_DEPTH);

  logic [OW-1:0] mem [MD];
  logic [CW-1:0] cnt_r [NUM_LEVELS];

  logic [LW-1:0] lvl_r, want_r;
  logic [CW-1:0] idx_r;
  logic [OW-1:0] off_r, rdata_r;
  logic          kind_r;
  logic [16:0]   size_r;
  logic [31:0]   addr_r;
  logic [1:0]    status_r;

  // block size of the current level; wraps to 0 at the whole pool
  logic [SW-1:0] shamt;
  logic [OW-1:0] bsize;
  logic [32:0]   lvl_bytes;
  assign shamt     = SW'(lvl_r) + SW'(MIN_BLOCK_LOG2);
  assign bsize     = OW'(1) << shamt;
  assign lvl_bytes = 33'd1 << shamt;

  logic [CW-1:0] cnt_cur;
  logic          cnt_full;
  assign cnt_cur  = cnt_r[lvl_r];
  assign cnt_full = (cnt_cur >= DEPTH_C);

  // memory addressing: one list of LIST_DEPTH slots per level
  logic [MW-1:0] lvl_base, rd_addr, wr_addr;
  logic [OW-1:0] wr_data;
  logic          push_ok, do_wr;
  assign lvl_base = MW'(lvl_r) * MW'(LIST_DEPTH);
  assign push_ok  = cmd.push_half && !cnt_full;
  assign do_wr    = cmd.init_wr | push_ok | cmd.push_off | cmd.wr_idx;

  always_comb begin
    if (cmd.rd_top)       rd_addr = lvl_base + MW'(cnt_cur - CW'(1));
    else if (cmd.rd_idx1) rd_addr = lvl_base + MW'(idx_r + CW'(1));
    else                  rd_addr = lvl_base + MW'(idx_r);
    if (cmd.init_wr) begin
      wr_addr = TOP_BASE;
      wr_data = '0;
    end else if (cmd.wr_idx) begin
      wr_addr = lvl_base + MW'(idx_r);
      wr_data = rdata_r;
    end else if (cmd.push_half) begin
      wr_addr = lvl_base + MW'(cnt_cur);
      wr_data = off_r | bsize;
    end else begin
      wr_addr = lvl_base + MW'(cnt_cur);
      wr_data = off_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_addr] <= wr_data;
    rdata_r <= mem[rd_addr];
  end

  // per-level counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_LEVELS; k++)
        cnt_r[k] <= (k == NUM_LEVELS - 1) ? CW'(1) : '0;
    end else begin
      if (cmd.pop || cmd.take_done)         cnt_r[lvl_r] <= cnt_cur - CW'(1);
      else if (push_ok || cmd.push_off)     cnt_r[lvl_r] <= cnt_cur + CW'(1);
    end
  end

  logic [31:0] rel;
  assign rel = req.free_address - pool_base;

  always_ff @(posedge clk) begin
    if (cmd.load)        lvl_r <= '0;
    else if (cmd.lvl_up) lvl_r <= lvl_r + LW'(1);
    else if (cmd.lvl_dn) lvl_r <= lvl_r - LW'(1);

    if (cmd.idx_clr)      idx_r <= '0;
    else if (cmd.idx_inc) idx_r <= idx_r + CW'(1);

    if (cmd.load)           off_r <= rel[OW-1:0];
    else if (cmd.pop)       off_r <= rdata_r;
    else if (cmd.align)     off_r <= off_r & ~(bsize - OW'(1));
    else if (cmd.take_done) off_r <= off_r & ~bsize;

    if (cmd.load) begin
      kind_r <= req.kind;
      size_r <= req.request_size;
    end
    if (cmd.set_want) want_r <= lvl_r;

    if (cmd.load)          addr_r <= '0;
    else if (cmd.set_addr) addr_r <= pool_base + 32'(off_r);
    if (cmd.set_status) status_r <= cmd.status;
  end

  always_comb begin
    sts.bad_size = (size_r == 17'd0) || ({16'd0, size_r} > POOL_BYTES);
    sts.is_free  = (kind_r == KIND_FREE);
    sts.fits     = ({16'd0, size_r} <= lvl_bytes);
    sts.at_want  = (lvl_r == want_r);
    sts.at_top   = (lvl_r == TOP);
    sts.cnt_zero = (cnt_cur == '0);
    sts.cnt_full = cnt_full;
    sts.idx_end  = (idx_r >= cnt_cur);
    sts.idx_last = ((idx_r + CW'(1)) >= cnt_cur);
    sts.match    = (rdata_r == (off_r ^ bsize));
  end

  assign result = {addr_r, status_r};

endmodule
`default_nettype wire

>>> design/buddy_block_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_block_allocator_core: buddy allocator over a power-of-two pool
// Steps: a bad size goes straight to the result; allocate searches up the levels,
//   pops a block and splits it down level by level; free scans each list for its buddy and merges upward.
// One word at a time: the next is taken after the result leaves.
// Reset (rst_n low, synchronous): top level holds the whole pool, base 0; after
//   reset an init state writes the top entry before in_ready rises.
// ----------------------------------------------------------------------------
module buddy_block_allocator_core #(
  parameter int POOL_LOG2      = 16,
  parameter int MIN_BLOCK_LOG2 = 4,
  parameter int LIST_DEPTH     = 64
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  bba_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output bba_pkg::out_word_t  out_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [31:0]         cfg_data
);
  import bba_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic busy, done;
  logic [31:0] pool_base_r;

  // base register, written only while idle
  assign cfg_ready = !busy;
  always_ff @(posedge clk) begin
    if (!rst_n) pool_base_r <= '0;
    else if (cfg_valid && cfg_ready) pool_base_r <= cfg_data;
  end

  assign in_ready  = !busy;
  assign out_valid = done;

  bba_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(in_valid), .out_taken(out_ready),
    .sts(sts), .cmd(cmd), .busy(busy), .done(done)
  );

  bba_dp #(
    .POOL_LOG2(POOL_LOG2), .MIN_BLOCK_LOG2(MIN_BLOCK_LOG2), .LIST_DEPTH(LIST_DEPTH)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .req(in_data), .pool_base(pool_base_r),
    .sts(sts), .result(out_data)
  );

  // a word is never taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during result");
  // result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");
  // one word in flight: input closes right after a word is taken
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second word taken");

endmodule
`default_nettype wire

>>> tb/tb_buddy_block_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator_core: self-checking bench for the buddy allocator
// Drives allocate/free words with random stalls, predicts every result word
// with a behavioral free-list model and compares each field in order.
// ----------------------------------------------------------------------------

// Scoreboard: behavioral free lists plus the queue of predicted words.
class buddy_scoreboard;
  localparam int POOL_LOG2 = 16;
  localparam int MIN_LOG2  = 4;
  localparam int DEPTH     = 64;
  localparam int LEVELS    = POOL_LOG2 - MIN_LOG2 + 1;
  localparam int TOP       = LEVELS - 1;

  bit [31:0] base;
  bit [15:0] blocks [LEVELS][DEPTH];
  int        fill [LEVELS];
  bba_pkg::out_word_t pending [$];
  int        errors;

  function new();
    base = 0;
    foreach (fill[l]) fill[l] = 0;
    blocks[TOP][0] = 0;
    fill[TOP] = 1;
    errors = 0;
  endfunction

  function automatic int level_of(bit [16:0] sz);
    int l;
    l = 0;
    while (l < TOP && (17'd1 << (l + MIN_LOG2)) < sz) l++;
    return l;
  endfunction

  // Removes the oldest matching entry, keeping order.
  function automatic bit take(int l, bit [15:0] off);
    for (int i = 0; i < fill[l]; i++) begin
      if (blocks[l][i] == off) begin
        for (int j = i; j < fill[l] - 1; j++) blocks[l][j] = blocks[l][j+1];
        fill[l]--;
        return 1;
      end
    end
    return 0;
  endfunction

  function void note_input(bba_pkg::in_word_t w);
    bba_pkg::out_word_t r;
    int want, l;
    bit [15:0] off;
    bit [31:0] rel;
    r = '0;
    r.status = bba_pkg::ST_OK;
    if (w.request_size == 0 || w.request_size > (17'd1 << POOL_LOG2)) begin
      r.status = bba_pkg::ST_BADSIZE;
    end else if (w.kind == bba_pkg::KIND_ALLOC) begin
      want = level_of(w.request_size);
      l = want;
      while (l <= TOP && fill[l] == 0) l++;
      if (l > TOP) begin
        r.status = bba_pkg::ST_EMPTY;
      end else begin
        fill[l]--;
        off = blocks[l][fill[l]];
        while (l > want) begin
          l--;
          if (fill[l] < DEPTH) begin
            blocks[l][fill[l]] = off + (16'd1 << (l + MIN_LOG2));
            fill[l]++;
          end
        end
        r.block_address = base + off;
      end
    end else begin
      l = level_of(w.request_size);
      rel = w.free_address - base;
      off = rel[15:0];
      off &= ~((16'd1 << (l + MIN_LOG2)) - 16'd1);
      while (l < TOP) begin
        if (!take(l, off ^ (16'd1 << (l + MIN_LOG2)))) break;
        off &= ~(16'd1 << (l + MIN_LOG2));
        l++;
      end
      if (fill[l] >= DEPTH) begin
        r.status = bba_pkg::ST_OVERFLOW;
      end else begin
        blocks[l][fill[l]] = off;
        fill[l]++;
      end
    end
    pending = {pending, r};
  endfunction

  task check_output(bba_pkg::out_word_t got);
    bba_pkg::out_word_t exp;
    if (pending.size() == 0) begin
      report_mismatch("result word with nothing pending", '0, got);
      return;
    end
    exp = pending.pop_front();
    if (got.block_address !== exp.block_address)
      report_mismatch("block_address", exp, got);
    if (got.status !== exp.status)
      report_mismatch("status", exp, got);
  endtask

  task report_mismatch(string what, bba_pkg::out_word_t exp,
                       bba_pkg::out_word_t got);
    errors++;
    $display("ERROR %s: exp addr=%h st=%0d got addr=%h st=%0d",
             what, exp.block_address, exp.status, got.block_address, got.status);
  endtask
endclass

module tb_buddy_block_allocator_core;
  import bba_pkg::*;

  localparam int WATCHDOG = 200000;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 0;
  out_word_t out_data;
  logic      cfg_valid = 0;
  logic      cfg_ready;
  logic [31:0] cfg_data = '0;

  buddy_scoreboard sb = new();

  bit  calm = 0;        // no idling in the final stretch
  int  hold_off = 0;    // long receiver stall request
  int  idle_cnt = 0;
  bit  [15:0] owned [$]; // offsets handed out, for well-formed frees
  int  owned_lvl [$];

  always #6 clk = ~clk;

  buddy_block_allocator_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off > 0) begin
        out_ready <= 0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 15);
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
    end
  end

  // Result checking at the edge where the word moves.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_output(out_data);
  end

  // Watchdog on cycles with no accepted word of any kind.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt > WATCHDOG) begin
      $display("buddy_block_allocator_core: mismatch");
      $finish;
    end
  end

  // Valid stays up after a word is taken; the next call replaces the word
  // in the same step, or drops valid before an idle burst.
  task automatic send_word(in_word_t w);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= w;
    @(posedge clk iff in_ready);
    sb.note_input(w);
  endtask

  task automatic write_base(logic [31:0] v);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1;
    cfg_data  <= v;
    @(posedge clk iff cfg_ready);
    sb.base = v;
    cfg_valid <= 0;
  endtask

  function automatic in_word_t make_word(bit kind, bit [16:0] sz, bit [31:0] a);
    in_word_t w;
    w.kind = kind;
    w.request_size = sz;
    w.free_address = a;
    return w;
  endfunction

  // Allocate and remember the block on success (from current prediction).
  task automatic alloc_rand(bit [16:0] sz);
    int lvl;
    bit [31:0] rel;
    send_word(make_word(KIND_ALLOC, sz, $urandom));
    if (sb.pending[$].status == ST_OK) begin
      lvl = sb.level_of(sz);
      rel = sb.pending[$].block_address - sb.base;
      owned = {owned, rel[15:0]};
      owned_lvl = {owned_lvl, lvl};
    end
  endtask

  task automatic free_owned();
    int k;
    bit [16:0] sz;
    k = $urandom_range(0, owned.size() - 1);
    sz = 17'd1 << (owned_lvl[k] + 4);
    if ($urandom_range(0, 1)) sz = 17'($urandom_range((sz >> 1) + 17'd1, sz));
    send_word(make_word(KIND_FREE, sz, sb.base + owned[k]));
    owned.delete(k);
    owned_lvl.delete(k);
  endtask

  function automatic bit [16:0] rand_size();
    int sh;
    sh = $urandom_range(0, 16);
    if ($urandom_range(0, 9) < 7) sh = $urandom_range(0, 8);
    return 17'($urandom_range(1, 32'd1 << sh));
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: send_word(make_word(1'($urandom_range(0, 1)), 17'($urandom), $urandom));
        1, 2, 3, 4: alloc_rand(rand_size());
        default: begin
          if (owned.size() > 0) free_owned();
          else alloc_rand(rand_size());
        end
      endcase
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: bad sizes, whole pool, small sizes, misaligned and
    // out-of-pool frees, double free, top-level push.
    send_word(make_word(KIND_ALLOC, 17'd0, 32'hFFFF_FFFF));
    send_word(make_word(KIND_FREE, 17'h1FFFF, 32'hFFFF_FFFF));
    send_word(make_word(KIND_ALLOC, 17'd65537, 32'd0));
    alloc_rand(17'd65536);
    send_word(make_word(KIND_ALLOC, 17'd1, 32'd0));
    send_word(make_word(KIND_FREE, 17'd65536, 32'h1234_0007));
    alloc_rand(17'd1);
    alloc_rand(17'd15);
    alloc_rand(17'd17);
    alloc_rand(17'd100);
    send_word(make_word(KIND_FREE, 17'd3, 32'd0));
    send_word(make_word(KIND_FREE, 17'd3, 32'd0));
    send_word(make_word(KIND_FREE, 17'd16, 32'hABCD_0013));
    send_word(make_word(KIND_FREE, 17'd32, 32'h0000_0025));
    send_word(make_word(KIND_FREE, 17'd128, 32'h0001_0080));
    owned.delete(); owned_lvl.delete();

    write_base(32'hFFFF_FFF0);
    alloc_rand(17'd32768);
    alloc_rand(17'd32768);
    send_word(make_word(KIND_FREE, 17'd32768, 32'hFFFF_FFF0));
    send_word(make_word(KIND_FREE, 17'd32768, 32'h0000_7FF0));

    // Overflow: free many distinct non-buddy minimum blocks repeatedly.
    write_base(32'd0);
    for (int i = 0; i < 70; i++)
      send_word(make_word(KIND_FREE, 17'd16, 32'(i) << 5));

    write_base($urandom);
    random_phase(300);

    // Long receiver stall while words keep coming.
    hold_off = 400;
    random_phase(40);

    write_base(32'h0000_0000);
    random_phase(300);
    write_base(32'hFFFF_FFFF);
    random_phase(200);
    write_base($urandom);
    calm = 1;
    random_phase(220);

    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0)
      $display("buddy_block_allocator_core: match");
    else
      $display("buddy_block_allocator_core: mismatch");
    $finish;
  end
endmodule
